// ===== hw/rtl/mslpf_pkg.sv =====
// ----------------------------------------------------------------------------
// mslpf_pkg: shared types and constants
// Sequencer states, register indexes, command codes and fixed arithmetic
// constants of the median and slew limited position filter.
// ----------------------------------------------------------------------------
package mslpf_pkg;

  // Register indexes of the configuration port
  localparam logic REG_RANGE = 1'b0;
  localparam logic REG_STEP  = 1'b1;

  // Command codes
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  // Converter full scale, the divisor of the scaling step
  localparam logic [10:0] ADC_FULL = 11'd1023;

  localparam logic signed [17:0] POS_MAX = 18'sd32767;
  localparam logic signed [17:0] POS_MIN = -18'sd32767;

  localparam logic [15:0] RANGE_RESET = 16'd10000;
  localparam logic [14:0] STEP_RESET  = 15'd300;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_DIV   = 9'b000000010,
    S_WRITE = 9'b000000100,
    S_CAND  = 9'b000001000,
    S_CANDL = 9'b000010000,
    S_CMP   = 9'b000100000,
    S_EVAL  = 9'b001000000,
    S_SLEW  = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_e;

endpackage

// ===== hw/rtl/mslpf_ram.sv =====
// ----------------------------------------------------------------------------
// mslpf_ram: generic single-write, single-read RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module mslpf_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 5
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hw/rtl/median_slew_limited_position_filter_unit.sv =====
// ----------------------------------------------------------------------------
// median_slew_limited_position_filter_unit: position filter top level
// Scales a converter reading to a signed position in hundredths of a mm,
// keeps it in a circular window, takes the window median and limits the
// change between consecutive outputs.
// ----------------------------------------------------------------------------
//  channel  direction  handshake              payload
//  in       input      in_valid_i/in_ready_o  cmd_i, adc_sample_i
//  out      output     out_valid_o/out_ready_i position_centi_mm_o
//  cfg      input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// A sample item runs through the division of the scaled product by 1023,
// done by folding steps, the window write, and a walk of one comparator over
// every pair of filled window entries through the single RAM read port; the
// median then passes the step limit and loads the output register. The
// block is ready again in the cycle after the output register is loaded,
// and stalls before loading it while a result still waits. A clear item is
// taken in the idle state and gives no result. A new item is accepted
// while a result still waits at the output. Reset clears the window state and
// loads the register defaults; no RAM clearing pass is needed.
// ----------------------------------------------------------------------------
module median_slew_limited_position_filter_unit
  import mslpf_pkg::*;
#(
  parameter int unsigned WINDOW = 5
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               cmd_i,
  input  logic [9:0]         adc_sample_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] position_centi_mm_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_index_i,
  input  logic [15:0]        cfg_data_i
);

  localparam int unsigned AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned CW = $clog2(WINDOW + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(WINDOW - 1);
  localparam logic [CW-1:0] WIN_CNT   = CW'(WINDOW);

  state_e state_q, state_d;

  logic [15:0] range_q;
  logic [14:0] step_q;

  logic [25:0] rem_q, rem_d;
  logic [15:0] quo_q, quo_d;

  logic [AW-1:0] slot_q, slot_d;
  logic [CW-1:0] count_q, count_d;
  logic          have_prev_q, have_prev_d;
  logic signed [15:0] prev_q, prev_d;

  logic [AW-1:0] i_q, i_d;
  logic [AW-1:0] j_q, j_d;
  logic [CW-1:0] lt_q, lt_d;
  logic [CW-1:0] le_q, le_d;
  logic signed [15:0] cand_q, cand_d;
  logic signed [15:0] lo_q, lo_d;
  logic signed [15:0] hi_q, hi_d;
  logic signed [15:0] res_q, res_d;

  logic               out_valid_q, out_valid_d;
  logic signed [15:0] out_data_q, out_data_d;

  // RAM ports
  logic          ram_we;
  logic [AW-1:0] ram_raddr;
  logic [15:0]   ram_rdata;
  logic [15:0]   pos_w;

  // Datapath helpers
  logic [25:0]        prod;
  logic signed [17:0] pos18;
  logic               cmp_less;
  logic               cmp_eq;
  logic [CW-1:0]      k_lo;
  logic [CW-1:0]      k_hi;
  logic [CW-1:0]      n_last;
  logic signed [16:0] mid_sum;
  logic signed [17:0] med18;
  logic signed [17:0] prev18;
  logic signed [17:0] step18;
  logic signed [17:0] delta18;
  logic signed [17:0] slew18;

  mslpf_ram #(
    .WIDTH (16),
    .DEPTH (WINDOW)
  ) u_window (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot_q),
    .wdata_i (pos_w),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_ready_o          = (state_q == S_IDLE);
  assign cfg_ready_o         = 1'b1;
  assign out_valid_o         = out_valid_q;
  assign position_centi_mm_o = out_data_q;

  assign prod = 26'(adc_sample_i) * 26'(range_q);

  assign pos18 = $signed({2'b00, quo_q}) - $signed({3'b000, range_q[15:1]});
  always_comb begin
    if (pos18 > POS_MAX) begin
      pos_w = POS_MAX[15:0];
    end else if (pos18 < POS_MIN) begin
      pos_w = POS_MIN[15:0];
    end else begin
      pos_w = pos18[15:0];
    end
  end

  // Shared comparator of the median walk
  assign cmp_less = ($signed(ram_rdata) < cand_q);
  assign cmp_eq   = (ram_rdata == cand_q);

  assign n_last = count_q - CW'(1);
  assign k_lo   = n_last >> 1;
  assign k_hi   = count_q >> 1;

  assign mid_sum = 17'(lo_q) + 17'(hi_q);
  assign med18   = 18'(mid_sum >>> 1);
  assign prev18  = 18'(prev_q);
  assign step18  = $signed({3'b000, step_q});
  assign delta18 = med18 - prev18;

  always_comb begin
    if (!have_prev_q) begin
      slew18 = med18;
    end else if (delta18 > step18) begin
      slew18 = prev18 + step18;
    end else if (delta18 < -step18) begin
      slew18 = prev18 - step18;
    end else begin
      slew18 = med18;
    end
  end

  always_comb begin
    state_d     = state_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    slot_d      = slot_q;
    count_d     = count_q;
    have_prev_d = have_prev_q;
    prev_d      = prev_q;
    i_d         = i_q;
    j_d         = j_q;
    lt_d        = lt_q;
    le_d        = le_q;
    cand_d      = cand_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    ram_we      = 1'b0;
    ram_raddr   = i_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (cmd_i == CMD_CLEAR) begin
            slot_d      = '0;
            count_d     = '0;
            have_prev_d = 1'b0;
            prev_d      = '0;
          end else begin
            rem_d   = prod;
            quo_d   = '0;
            state_d = S_DIV;
          end
        end
      end
      S_DIV: begin
        // fold the bits above 2^10 back in: a*1024 + b = a*1023 + (a + b)
        if (rem_q[25:10] != '0) begin
          quo_d = quo_q + rem_q[25:10];
          rem_d = 26'(rem_q[25:10]) + 26'(rem_q[9:0]);
        end else begin
          if (rem_q[10:0] == ADC_FULL) begin
            quo_d = quo_q + 16'd1;
          end
          state_d = S_WRITE;
        end
      end
      S_WRITE: begin
        ram_we  = 1'b1;
        slot_d  = (slot_q == LAST_SLOT) ? '0 : slot_q + AW'(1);
        if (count_q != WIN_CNT) begin
          count_d = count_q + CW'(1);
        end
        i_d     = '0;
        state_d = S_CAND;
      end
      S_CAND: begin
        ram_raddr = i_q;
        state_d   = S_CANDL;
      end
      S_CANDL: begin
        cand_d    = ram_rdata;
        ram_raddr = '0;
        j_d       = '0;
        lt_d      = '0;
        le_d      = '0;
        state_d   = S_CMP;
      end
      S_CMP: begin
        // read data belongs to entry j; fetch the next one
        ram_raddr = (j_q == LAST_SLOT) ? '0 : j_q + AW'(1);
        j_d       = j_q + AW'(1);
        if (cmp_less) begin
          lt_d = lt_q + CW'(1);
        end
        if (cmp_less || cmp_eq) begin
          le_d = le_q + CW'(1);
        end
        if (CW'(j_q) == n_last) begin
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        // candidate holds every rank from lt up to le-1
        if (lt_q <= k_lo && k_lo < le_q) begin
          lo_d = cand_q;
        end
        if (lt_q <= k_hi && k_hi < le_q) begin
          hi_d = cand_q;
        end
        if (CW'(i_q) == n_last) begin
          state_d = S_SLEW;
        end else begin
          i_d     = i_q + AW'(1);
          state_d = S_CAND;
        end
      end
      S_SLEW: begin
        res_d       = slew18[15:0];
        prev_d      = slew18[15:0];
        have_prev_d = 1'b1;
        state_d     = S_OUT;
      end
      S_OUT: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_data_d  = res_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      range_q     <= RANGE_RESET;
      step_q      <= STEP_RESET;
      slot_q      <= '0;
      count_q     <= '0;
      have_prev_q <= 1'b0;
      prev_q      <= '0;
      i_q         <= '0;
      j_q         <= '0;
      lt_q        <= '0;
      le_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      slot_q      <= slot_d;
      count_q     <= count_d;
      have_prev_q <= have_prev_d;
      prev_q      <= prev_d;
      i_q         <= i_d;
      j_q         <= j_d;
      lt_q        <= lt_d;
      le_q        <= le_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          REG_RANGE: range_q <= cfg_data_i;
          REG_STEP:  step_q  <= cfg_data_i[14:0];
          default:   range_q <= range_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q      <= rem_d;
    quo_q      <= quo_d;
    cand_q     <= cand_d;
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    res_q      <= res_d;
    out_data_q <= out_data_d;
  end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: median slew limited position filter
// Sends samples and clears in random bursts while the output stalls on its
// own pattern. Every position is checked against an in-line model of the
// scaling, the window median and the step limit, across several register
// settings that include the extremes.
// ----------------------------------------------------------------------------
module testbench
  import mslpf_pkg::*;
();

  localparam int unsigned WINDOW          = 5;
  localparam int unsigned SETTLE_CYCLES   = 80;
  localparam int unsigned HOLD_OFF_CYCLES = 500;
  localparam int unsigned DRAIN_LIMIT     = 20000;
  localparam int unsigned RANDOM_PHASES   = 11;
  localparam int unsigned PHASE_ITEMS     = 145;

  typedef enum int unsigned {
    READY_ALWAYS,
    READY_MOSTLY,
    READY_RARELY,
    READY_PERIODIC
  } ready_mode_e;

  logic               clk_i        = 1'b0;
  logic               rst_ni       = 1'b0;
  logic               in_valid_i   = 1'b0;
  logic               in_ready_o;
  logic               cmd_i        = CMD_SAMPLE;
  logic [9:0]         adc_sample_i = '0;
  logic               out_valid_o;
  logic               out_ready_i  = 1'b0;
  logic signed [15:0] position_centi_mm_o;
  logic               cfg_valid_i  = 1'b0;
  logic               cfg_ready_o;
  logic               cfg_index_i  = REG_RANGE;
  logic [15:0]        cfg_data_i   = '0;

  // model copy of the registers and the filter history
  logic [15:0]        range_reg;
  logic [14:0]        step_reg;
  int                 window_pos [WINDOW];
  int unsigned        next_slot;
  int unsigned        filled;
  bit                 have_prev;
  int                 prev_out;

  logic signed [15:0] pending_positions [$];
  int unsigned        mismatch_count = 0;
  int unsigned        burst_left     = 0;
  int unsigned        hold_request   = 0;
  logic [9:0]         walk_adc       = 10'd512;

  median_slew_limited_position_filter_unit #(
    .WINDOW(WINDOW)
  ) uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .cmd_i              (cmd_i),
    .adc_sample_i       (adc_sample_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .position_centi_mm_o(position_centi_mm_o),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic void clear_history();
    foreach (window_pos[k]) window_pos[k] = 0;
    next_slot = 0;
    filled    = 0;
    have_prev = 1'b0;
    prev_out  = 0;
  endfunction

  function automatic int scaled_position(logic [9:0] adc);
    int unsigned product;
    int          pos;
    product = 32'(adc) * 32'(range_reg);
    pos = int'(product / 1023) - int'(range_reg >> 1);
    if (pos > 32767) pos = 32767;
    if (pos < -32767) pos = -32767;
    return pos;
  endfunction

  function automatic int window_median();
    int          sorted [WINDOW];
    int          key;
    int unsigned i;
    int unsigned j;
    if (filled == 0) return 0;
    for (i = 0; i < filled; i++) sorted[i] = window_pos[i];
    for (i = 1; i < filled; i++) begin
      key = sorted[i];
      j = i;
      while (j > 0 && sorted[j - 1] > key) begin
        sorted[j] = sorted[j - 1];
        j--;
      end
      sorted[j] = key;
    end
    // floored mean of the two middle entries for an even count
    if (filled % 2 == 0) return (sorted[filled / 2 - 1] + sorted[filled / 2]) >>> 1;
    return sorted[filled / 2];
  endfunction

  function automatic logic signed [15:0] filter_position(logic [9:0] adc);
    int value;
    int limit;
    window_pos[next_slot] = scaled_position(adc);
    next_slot = (next_slot + 1) % WINDOW;
    if (filled < WINDOW) filled++;
    value = window_median();
    limit = int'(step_reg);
    // first result after a clear passes unchanged
    if (have_prev) begin
      if (value - prev_out > limit) value = prev_out + limit;
      else if (value - prev_out < -limit) value = prev_out - limit;
    end
    have_prev = 1'b1;
    prev_out  = value;
    return value[15:0];
  endfunction

  function automatic void note_mismatch(string what, int want, logic signed [15:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t: %s: expected %0d, got %0d", $realtime, what, want, got);
  endfunction

  function automatic logic [9:0] pick_adc();
    int w;
    case ($urandom_range(0, 5))
      0: walk_adc = 10'($urandom_range(0, 1023));
      1: walk_adc = $urandom_range(0, 1) ? 10'($urandom_range(0, 3))
                                         : 10'($urandom_range(1020, 1023));
      default: begin
        // slow drift keeps the output inside the step limit for a while
        w = int'(walk_adc) + int'($urandom_range(0, 40)) - 20;
        if (w < 0) w = 0;
        if (w > 1023) w = 1023;
        walk_adc = w[9:0];
      end
    endcase
    return walk_adc;
  endfunction

  task automatic send_item(logic cmd, logic [9:0] adc, bit back_to_back);
    int unsigned gap;
    if (!back_to_back && burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      case ($urandom_range(0, 3))
        0:       gap = 0;
        1, 2:    gap = $urandom_range(1, 5);
        default: gap = $urandom_range(6, 70);
      endcase
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    if (burst_left != 0) burst_left--;
    in_valid_i   <= 1'b1;
    cmd_i        <= cmd;
    adc_sample_i <= adc;
    do @(posedge clk_i); while (!in_ready_o);
    if (cmd == CMD_CLEAR) clear_history();
    else pending_positions.push_back(filter_position(adc));
  endtask

  task automatic wait_results();
    int unsigned waited;
    waited = 0;
    in_valid_i <= 1'b0;
    while (pending_positions.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
  endtask

  // a trailing clear leaves no result to wait for, so allow for its latency
  task automatic wait_idle();
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_config(logic [15:0] range_word, logic [15:0] step_word);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= REG_RANGE;
    cfg_data_i  <= range_word;
    do @(posedge clk_i); while (!cfg_ready_o);
    range_reg = range_word;
    cfg_index_i <= REG_STEP;
    cfg_data_i  <= step_word;
    do @(posedge clk_i); while (!cfg_ready_o);
    step_reg = step_word[14:0];
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_reset_defaults();
    send_item(CMD_SAMPLE, 10'd0, 1'b0);
    send_item(CMD_SAMPLE, 10'd1023, 1'b0);
    send_item(CMD_SAMPLE, 10'd1023, 1'b0);
    send_item(CMD_SAMPLE, 10'd512, 1'b0);
    send_item(CMD_CLEAR, 10'h3FF, 1'b0);
    send_item(CMD_SAMPLE, 10'd1023, 1'b0);
    send_item(CMD_SAMPLE, 10'd0, 1'b0);
    send_item(CMD_SAMPLE, 10'd341, 1'b0);
    send_item(CMD_SAMPLE, 10'd682, 1'b0);
    send_item(CMD_SAMPLE, 10'h2AA, 1'b0);
    send_item(CMD_SAMPLE, 10'h155, 1'b0);
  endtask

  task automatic test_config_extremes();
    // zero range: every position is zero
    wait_idle();
    set_config(16'd0, 16'h7FFF);
    send_item(CMD_SAMPLE, 10'd1023, 1'b0);
    send_item(CMD_SAMPLE, 10'd0, 1'b0);
    send_item(CMD_SAMPLE, 10'd512, 1'b0);
    // full-scale range: top reading saturates
    wait_idle();
    set_config(16'hFFFF, 16'h7FFF);
    send_item(CMD_SAMPLE, 10'd1023, 1'b0);
    send_item(CMD_SAMPLE, 10'd1023, 1'b0);
    send_item(CMD_SAMPLE, 10'd0, 1'b0);
    send_item(CMD_SAMPLE, 10'd1, 1'b0);
    // zero step: output frozen until a clear; bit 15 of the data is dropped
    wait_idle();
    set_config(16'd65534, 16'h8000);
    send_item(CMD_SAMPLE, 10'd0, 1'b0);
    send_item(CMD_SAMPLE, 10'd1023, 1'b0);
    send_item(CMD_SAMPLE, 10'd1023, 1'b0);
    send_item(CMD_CLEAR, 10'd0, 1'b0);
    send_item(CMD_SAMPLE, 10'd1023, 1'b0);
    send_item(CMD_SAMPLE, 10'd0, 1'b0);
  endtask

  task automatic test_output_backpressure();
    wait_idle();
    set_config(RANGE_RESET, 16'(STEP_RESET));
    hold_request = HOLD_OFF_CYCLES;
    repeat (24) send_item(CMD_SAMPLE, pick_adc(), 1'b1);
    wait_results();
  endtask

  task automatic test_sender_pause();
    repeat (4) begin
      repeat (5) send_item(CMD_SAMPLE, pick_adc(), 1'b0);
      wait_results();
    end
  endtask

  task automatic test_random_phases();
    logic [15:0] range_word;
    logic [15:0] step_word;
    repeat (RANDOM_PHASES) begin
      case ($urandom_range(0, 9))
        0:       range_word = 16'd0;
        1:       range_word = 16'hFFFF;
        2:       range_word = 16'd65534;
        3:       range_word = 16'd1;
        4:       range_word = RANGE_RESET;
        default: range_word = 16'($urandom_range(1, 65534));
      endcase
      case ($urandom_range(0, 7))
        0:       step_word = 16'd0;
        1:       step_word = 16'h7FFF;
        2:       step_word = 16'd1;
        3:       step_word = 16'($urandom);
        default: step_word = 16'($urandom_range(0, 600));
      endcase
      wait_idle();
      set_config(range_word, step_word);
      repeat (PHASE_ITEMS) begin
        if ($urandom_range(0, 39) == 0)
          send_item(CMD_CLEAR, 10'($urandom_range(0, 1023)), 1'b0);
        else
          send_item(CMD_SAMPLE, pick_adc(), 1'b0);
      end
    end
  endtask

  // output stall pattern, with a long hold-off on request
  initial begin : output_stall_pattern
    int unsigned stall_left;
    int unsigned pattern_left;
    int unsigned tick;
    ready_mode_e mode;
    stall_left   = 0;
    pattern_left = 0;
    tick         = 0;
    mode         = READY_ALWAYS;
    forever begin
      @(posedge clk_i);
      if (hold_request != 0) begin
        stall_left   = hold_request;
        hold_request = 0;
      end
      if (pattern_left == 0) begin
        mode = ready_mode_e'($urandom_range(0, 3));
        pattern_left = $urandom_range(20, 300);
      end
      pattern_left--;
      tick++;
      if (stall_left != 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        case (mode)
          READY_ALWAYS: out_ready_i <= 1'b1;
          READY_MOSTLY: out_ready_i <= ($urandom_range(0, 3) != 0);
          READY_RARELY: out_ready_i <= ($urandom_range(0, 3) == 0);
          default:      out_ready_i <= (tick % 5 < 2);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin : position_check
    logic signed [15:0] expected;
    if (out_valid_o && out_ready_i) begin
      if (pending_positions.size() == 0) begin
        note_mismatch("position with no sample pending", 0, position_centi_mm_o);
      end else begin
        expected = pending_positions.pop_front();
        if (position_centi_mm_o !== expected)
          note_mismatch("position", expected, position_centi_mm_o);
      end
    end
  end

  initial begin
    range_reg = RANGE_RESET;
    step_reg  = STEP_RESET;
    clear_history();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_config_extremes();
    test_output_backpressure();
    test_sender_pause();
    test_random_phases();
    wait_idle();
    if (pending_positions.size() != 0) begin
      $display("%0d expected positions never arrived", pending_positions.size());
      mismatch_count += pending_positions.size();
    end
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("timeout");
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/mslpf_pkg.sv
hw/rtl/mslpf_ram.sv
hw/rtl/median_slew_limited_position_filter_unit.sv
test/testbench.sv
